>>> rtl/fpsa_pkg.sv
// Shared constants, codes and types for the fit policy segment allocator.
// Used by fpsa_fit_eval and by the top level fit_policy_segment_allocator_unit.
// No dependencies.
package fpsa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int ADDR_W       = 32;
  localparam int LEN_W        = 32;
  localparam int ENTRY_W      = ADDR_W + LEN_W;

  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 5;

  localparam int IN_FIELDS_W  = 4 + 32 + 32 + 32 + 32;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 + 32 + 32;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_ALLOC   = 2'd1,
    REQ_RECLAIM = 2'd2,
    REQ_NONE    = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_NEXT  = 2'd2,
    MODE_SPARE = 2'd3
  } fit_mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_BADINDEX = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_FIT_MODE  = 1'd0,
    CFG_SEG_COUNT = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Result of checking one table entry against the current request.
  typedef struct packed {
    logic             fits;
    logic             better;
    logic [LEN_W-1:0] slack;
  } fit_eval_t;

endpackage

>>> rtl/fit_policy_segment_allocator_unit.sv
// Top level of the fit policy segment allocator: handshakes, sequencer and segment table.
// Depends on fpsa_pkg and fpsa_fit_eval.
//
// Usage: request items enter on the s_* stream, with the request kind in s_tuser
// (load, allocate, reclaim). Each item yields exactly one result item on the m_*
// stream, with the status code in m_tuser and the entry index, start and length
// in m_tdata. The cfg_* port writes the fit mode and the number of entries in use;
// the user must write only while the block is idle; the block does not enforce it.
// Timing: a load, an unknown request, or an allocate or reclaim with no entries in
// use goes from acceptance straight to the done state, from which the result moves
// to the output register. An allocate or reclaim scans the table one entry per cycle
// through the single read port of the segment memory, then goes to the done state.
// With n the number of entries in use (at most 16), first fit, next fit and reclaim
// stop early at the first match, best fit always visits all n entries. One item is
// worked on at a time; the next item is taken as soon as the result has moved to the
// output register, even if the receiver has not yet taken it.
// Reset: all entries free, no previous allocation, fit mode first fit and zero
// entries in use. The table contents are not cleared; loads define them.
// Stall: while m_tready is low the result holds in the output register, and a
// later finished result waits in the sequencer, which then holds s_tready low.
module fit_policy_segment_allocator_unit
  import fpsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // From bit 0: load_index[4], load_start[32], load_length[32], request_size[32],
  // reclaim_start[32], zero pad[4].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // req_type[2].
  input  logic [1:0]            s_tuser,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // From bit 0: hit_index[4], hit_start[32], hit_length[32], zero pad[4].
  output logic [OUT_DATA_W-1:0] m_tdata,
  // status[2].
  output logic [1:0]            m_tuser
);

  // Configuration registers.
  logic [1:0]       fit_mode;
  logic [CNT_W-1:0] segment_count;

  // Sequencer state.
  state_t           state, state_next;
  req_kind_t        req_kind;
  fit_mode_t        req_mode;
  logic [LEN_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;
  logic [IDX_W-1:0] cur_idx;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] last_pos;

  // Best fit tracking.
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [ADDR_W-1:0] best_start;
  logic [LEN_W-1:0] best_len;
  logic [LEN_W-1:0] best_slack;

  // Next fit memory.
  logic [IDX_W-1:0] last_alloc_index;
  logic             last_alloc_valid;

  // Busy marks live in flops so that reset frees every entry at once.
  logic [MAX_SEGMENTS-1:0] seg_busy;

  // Pending result, waiting for the output register.
  status_t           res_status;
  logic [IDX_W-1:0]  res_idx;
  logic [ADDR_W-1:0] res_start;
  logic [LEN_W-1:0]  res_len;

  // Segment table memory: start address in the upper half, length in the lower.
  logic [ENTRY_W-1:0] seg_mem [MAX_SEGMENTS];
  logic [ENTRY_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;

  // Input fields.
  req_kind_t         in_kind;
  logic [IDX_W-1:0]  in_load_index;
  logic [ADDR_W-1:0] in_load_start;
  logic [LEN_W-1:0]  in_load_length;
  logic [LEN_W-1:0]  in_request_size;
  logic [ADDR_W-1:0] in_reclaim_start;

  assign in_kind          = req_kind_t'(s_tuser);
  assign in_load_index    = s_tdata[3:0];
  assign in_load_start    = s_tdata[35:4];
  assign in_load_length   = s_tdata[67:36];
  assign in_request_size  = s_tdata[99:68];
  assign in_reclaim_start = s_tdata[131:100];

  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  n_used;
  logic [IDX_W-1:0]  start_pos;
  logic              load_ok;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Entries taking part in a scan; a count above the table size acts as the size.
  assign n_used = (segment_count > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                         : segment_count;

  // Next fit resumes at the last allocated entry when that is still in range.
  // Reclaim and the other policies always scan from entry zero.
  always_comb begin
    start_pos = '0;
    if ((in_kind == REQ_ALLOC) && (fit_mode == MODE_NEXT) && last_alloc_valid &&
        ({1'b0, last_alloc_index} < n_used)) begin
      start_pos = last_alloc_index;
    end
  end

  assign load_ok = ({1'b0, in_load_index} < CNT_W'(MAX_SEGMENTS));

  // Current entry, read out of the memory in the previous cycle.
  logic [ADDR_W-1:0] ent_start;
  logic [LEN_W-1:0]  ent_len;
  fit_eval_t         ev;
  logic              is_alloc;
  logic              is_best;
  logic              hit_now;
  logic              last_step;
  logic [IDX_W-1:0]  nxt_idx;
  logic              take_cur;

  assign ent_start = rd_data[ENTRY_W-1:LEN_W];
  assign ent_len   = rd_data[LEN_W-1:0];
  assign is_alloc  = (req_kind == REQ_ALLOC);
  assign is_best   = is_alloc && (req_mode == MODE_BEST);

  fpsa_fit_eval u_fit_eval (
    .busy       (seg_busy[cur_idx]),
    .seg_length (ent_len),
    .req_size   (req_size),
    .best_slack (best_slack),
    .eval       (ev)
  );

  // First fit, next fit and reclaim stop at the first match.
  assign hit_now   = is_alloc ? (!is_best && ev.fits) : (ent_start == req_addr);
  assign last_step = (step == last_pos);
  assign nxt_idx   = (cur_idx == last_pos) ? '0 : cur_idx + 1'b1;
  // Best fit: the current entry replaces the stored best this cycle.
  assign take_cur  = is_best && ev.fits && (!best_found || ev.better);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (((in_kind == REQ_ALLOC) || (in_kind == REQ_RECLAIM)) && (n_used != '0)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (hit_now || last_step) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Read address: the first entry when a scan starts, then the following one.
  always_comb begin
    rd_addr = nxt_idx;
    if (state == S_IDLE) begin
      rd_addr = start_pos;
    end
  end

  assign mem_we = accept && (in_kind == REQ_LOAD) && load_ok;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[in_load_index] <= {in_load_start, in_load_length};
    end
    rd_data <= seg_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      fit_mode         <= MODE_FIRST;
      segment_count    <= '0;
      seg_busy         <= '0;
      last_alloc_index <= '0;
      last_alloc_valid <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_FIT_MODE:  fit_mode      <= cfg_data[1:0];
          CFG_SEG_COUNT: segment_count <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end

      if (mem_we) begin
        seg_busy[in_load_index] <= 1'b0;
      end

      if (state == S_SCAN) begin
        if (hit_now) begin
          seg_busy[cur_idx] <= is_alloc;
          if (is_alloc && (req_mode == MODE_NEXT)) begin
            last_alloc_index <= cur_idx;
            last_alloc_valid <= 1'b1;
          end
        end else if (last_step && is_best && (best_found || take_cur)) begin
          seg_busy[take_cur ? cur_idx : best_idx] <= 1'b1;
        end
      end

      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Request, scan and result payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req_kind   <= in_kind;
          // An unknown mode behaves as first fit.
          req_mode   <= (fit_mode == MODE_SPARE) ? MODE_FIRST : fit_mode_t'(fit_mode);
          req_size   <= in_request_size;
          req_addr   <= in_reclaim_start;
          cur_idx    <= start_pos;
          step       <= '0;
          last_pos   <= IDX_W'(n_used - 1'b1);
          best_found <= 1'b0;
          best_slack <= '1;
          res_status <= ST_OK;
          res_idx    <= '0;
          res_start  <= '0;
          res_len    <= '0;
          case (in_kind)
            REQ_LOAD: begin
              if (load_ok) begin
                res_idx   <= in_load_index;
                res_start <= in_load_start;
                res_len   <= in_load_length;
              end else begin
                res_status <= ST_BADINDEX;
              end
            end
            REQ_ALLOC:   res_status <= ST_NOFIT;
            REQ_RECLAIM: res_status <= ST_NOTFOUND;
            default:     res_status <= ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        if (take_cur) begin
          best_found <= 1'b1;
          best_idx   <= cur_idx;
          best_start <= ent_start;
          best_len   <= ent_len;
          best_slack <= ev.slack;
        end
        if (hit_now) begin
          res_status <= ST_OK;
          res_idx    <= cur_idx;
          res_start  <= ent_start;
          res_len    <= ent_len;
        end else if (last_step) begin
          if (take_cur) begin
            res_status <= ST_OK;
            res_idx    <= cur_idx;
            res_start  <= ent_start;
            res_len    <= ent_len;
          end else if (is_best && best_found) begin
            res_status <= ST_OK;
            res_idx    <= best_idx;
            res_start  <= best_start;
            res_len    <= best_len;
          end
          // Otherwise the failure status set at acceptance stands.
        end else begin
          step    <= step + 1'b1;
          cur_idx <= nxt_idx;
        end
      end
      S_DONE: begin
        if (out_free) begin
          m_tuser <= res_status;
          m_tdata <= {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, res_len, res_start, res_idx};
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/fpsa_fit_eval.sv
// Per-entry fit check: does a free entry hold the request, and does it beat the best so far.
// Depends on fpsa_pkg.
module fpsa_fit_eval
  import fpsa_pkg::*;
(
  input  logic             busy,
  input  logic [LEN_W-1:0] seg_length,
  input  logic [LEN_W-1:0] req_size,
  input  logic [LEN_W-1:0] best_slack,
  output fit_eval_t        eval
);

  logic [LEN_W:0] diff;

  // The borrow bit of the subtraction is set exactly when the entry is too short.
  assign diff        = {1'b0, seg_length} - {1'b0, req_size};
  assign eval.fits   = !busy && !diff[LEN_W];
  assign eval.slack  = diff[LEN_W-1:0];
  // Equal slack counts as better, so the last of equal fits wins.
  assign eval.better = diff[LEN_W-1:0] <= best_slack;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for fit_policy_segment_allocator_unit: directed cases, then random traffic.
// Depends on fpsa_pkg and the RTL of the allocator; needs no other file.
module tb_top;
  import fpsa_pkg::*;

  // One request item as the bench sees it, before packing onto the stream.
  typedef struct {
    req_kind_t   kind;
    logic [3:0]  load_index;
    logic [31:0] load_start;
    logic [31:0] load_length;
    logic [31:0] request_size;
    logic [31:0] reclaim_start;
  } seg_req_t;

  // One result item, unpacked from m_tuser and m_tdata.
  typedef struct {
    status_t     status;
    logic [3:0]  index;
    logic [31:0] start;
    logic [31:0] length;
  } seg_result_t;

  localparam int STALL_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  // From bit 0: load_index[4], load_start[32], load_length[32], request_size[32],
  // reclaim_start[32], zero pad[4].
  logic [IN_DATA_W-1:0]  s_tdata;
  // req_type[2].
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  // From bit 0: hit_index[4], hit_start[32], hit_length[32], zero pad[4].
  logic [OUT_DATA_W-1:0] m_tdata;
  // status[2].
  logic [1:0]            m_tuser;

  // The bench's own copy of the segment table, the next fit pointer and the
  // two configuration registers. It is advanced once per accepted request.
  logic [31:0] table_start [MAX_SEGMENTS];
  logic [31:0] table_length[MAX_SEGMENTS];
  logic        table_busy  [MAX_SEGMENTS];
  logic [3:0]  next_fit_index;
  logic        next_fit_valid;
  fit_mode_t   policy;
  logic [4:0]  entries_cfg;

  // Results predicted for accepted requests, oldest first.
  seg_result_t pending_results[$];

  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  fit_policy_segment_allocator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Number of table entries that take part in a scan; larger counts clamp to
  // the table size.
  function automatic int entries_in_scan();
    return (entries_cfg > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(entries_cfg);
  endfunction

  function automatic logic entry_fits(int i, logic [31:0] size);
    return !table_busy[i] && (table_length[i] >= size);
  endfunction

  // Chooses the entry for an allocate under the current policy, -1 when none
  // fits. Only next fit moves the pointer; the spare mode code behaves as
  // first fit.
  function automatic int choose_entry(logic [31:0] size);
    int n;
    int best;
    int pos;
    logic [31:0] best_slack;
    n = entries_in_scan();
    best = -1;
    best_slack = 32'hFFFF_FFFF;
    if (policy == MODE_BEST) begin
      // Ties go to the highest index, hence the non-strict compare.
      for (int i = 0; i < n; i++) begin
        if (entry_fits(i, size) && (table_length[i] - size) <= best_slack) begin
          best_slack = table_length[i] - size;
          best = i;
        end
      end
      return best;
    end
    if (policy == MODE_NEXT) begin
      // A pointer left outside the entries in use restarts the scan at zero.
      pos = next_fit_valid ? int'(next_fit_index) : 0;
      if (pos >= n) pos = 0;
      for (int i = 0; i < n; i++) begin
        if (entry_fits(pos, size)) begin
          next_fit_index = pos[3:0];
          next_fit_valid = 1'b1;
          return pos;
        end
        pos = (pos + 1 >= n) ? 0 : pos + 1;
      end
      return -1;
    end
    for (int i = 0; i < n; i++) begin
      if (entry_fits(i, size)) return i;
    end
    return -1;
  endfunction

  // Works out the result of one accepted request and updates the table copy.
  // Fields that carry no meaning for a status other than ok stay zero.
  function automatic seg_result_t predict_allocator_result(seg_req_t r);
    seg_result_t res;
    int hit;
    int n;
    res = '{ST_OK, 4'd0, 32'd0, 32'd0};
    hit = -1;
    case (r.kind)
      REQ_LOAD: begin
        // The index field is four bits wide, so a load is never out of range.
        hit = int'(r.load_index);
        table_start[hit] = r.load_start;
        table_length[hit] = r.load_length;
        table_busy[hit] = 1'b0;
      end
      REQ_ALLOC: begin
        hit = choose_entry(r.request_size);
        if (hit < 0) res.status = ST_NOFIT;
        else table_busy[hit] = 1'b1;
      end
      REQ_RECLAIM: begin
        // The lowest matching entry is freed, busy or not.
        n = entries_in_scan();
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && table_start[i] == r.reclaim_start) hit = i;
        end
        if (hit < 0) res.status = ST_NOTFOUND;
        else table_busy[hit] = 1'b0;
      end
      default: ;
    endcase
    if (hit >= 0) begin
      res.index = hit[3:0];
      res.start = table_start[hit];
      res.length = table_length[hit];
    end
    return res;
  endfunction

  // Result checker: every accepted result is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    seg_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d index=%0d start=%h length=%h",
                 $time, m_tuser, m_tdata[3:0], m_tdata[35:4], m_tdata[67:36]);
        failures++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tuser !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, m_tuser);
          failures++;
        end
        if (m_tdata[3:0] !== exp_res.index) begin
          $display("%0t: hit_index expected %0d actual %0d",
                   $time, exp_res.index, m_tdata[3:0]);
          failures++;
        end
        if (m_tdata[35:4] !== exp_res.start) begin
          $display("%0t: hit_start expected %h actual %h",
                   $time, exp_res.start, m_tdata[35:4]);
          failures++;
        end
        if (m_tdata[67:36] !== exp_res.length) begin
          $display("%0t: hit_length expected %h actual %h",
                   $time, exp_res.length, m_tdata[67:36]);
          failures++;
        end
      end
    end
  end

  // The receiver drops ready at random according to the current stall rate.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: ends the run when neither stream has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Offers one request, holding it until the block takes it, then records
  // the prediction. Valid is left high so back to back items need no gap;
  // a random idle cycle lowers it at the next falling edge.
  task automatic send_item(seg_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {4'b0, r.reclaim_start, r.request_size, r.load_length, r.load_start,
                r.load_index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(predict_allocator_result(r));
  endtask

  task automatic drop_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Register writes happen only with the block idle: valid is lowered and
  // every predicted result must have come back first.
  task automatic write_reg(cfg_reg_t sel, logic [4:0] value);
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    if (sel == CFG_FIT_MODE) policy = fit_mode_t'(value[1:0]);
    else entries_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A request of the given kind with every field filled at random; the
  // fields that matter are overwritten by the caller.
  function automatic seg_req_t blank_req(req_kind_t kind);
    seg_req_t r;
    r.kind = kind;
    r.load_index = 4'($urandom());
    r.load_start = $urandom();
    r.load_length = $urandom();
    r.request_size = $urandom();
    r.reclaim_start = $urandom();
    return r;
  endfunction

  task automatic send_load(logic [3:0] idx, logic [31:0] start, logic [31:0] length);
    seg_req_t r;
    r = blank_req(REQ_LOAD);
    r.load_index = idx;
    r.load_start = start;
    r.load_length = length;
    send_item(r);
  endtask

  task automatic send_alloc(logic [31:0] size);
    seg_req_t r;
    r = blank_req(REQ_ALLOC);
    r.request_size = size;
    send_item(r);
  endtask

  task automatic send_reclaim(logic [31:0] addr);
    seg_req_t r;
    r = blank_req(REQ_RECLAIM);
    r.reclaim_start = addr;
    send_item(r);
  endtask

  // After reset no entry is in use: allocate finds nothing, reclaim finds
  // nothing, and an unknown request just returns zeros.
  task automatic test_empty_table();
    seg_req_t r;
    send_alloc(32'd0);
    send_reclaim(32'd0);
    r = blank_req(REQ_NONE);
    r.load_index = '1;
    r.load_start = '1;
    r.load_length = '1;
    r.request_size = '1;
    r.reclaim_start = '1;
    send_item(r);
  endtask

  // Four entries with extreme starts and lengths, two of them sharing a start
  // address, plus the top index outside the scanned range.
  task automatic test_load_entries();
    send_load(4'd0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_load(4'd1, 32'h0000_1000, 32'h0000_0100);
    send_load(4'd2, 32'h0000_1000, 32'h0000_0100);
    send_load(4'd3, 32'hFFFF_FFFF, 32'h0000_0000);
    send_load(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_SEG_COUNT, 5'd4);
  endtask

  // First fit with the largest and the zero size, then a request nothing meets.
  task automatic test_first_fit();
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'd0);
    send_alloc(32'hFFFF_FFFF);
  endtask

  // Reclaim frees the lowest of two entries with the same start, also when it
  // is already free, and reports an address that is not in the table.
  task automatic test_reclaim();
    send_reclaim(32'h0000_1000);
    send_reclaim(32'h0000_1000);
    send_reclaim(32'h0000_0000);
    send_reclaim(32'h0000_1234);
  endtask

  // Best fit: equal slack picks the higher entry, and an exact fit wins.
  task automatic test_best_fit();
    write_reg(CFG_FIT_MODE, {3'b0, MODE_BEST});
    send_alloc(32'h0000_0080);
    send_alloc(32'd0);
    send_alloc(32'd0);
  endtask

  // Next fit: the pointer starts at zero, a shrunken count makes it stale,
  // and a scan from the last entry wraps around to the first.
  task automatic test_next_fit();
    write_reg(CFG_FIT_MODE, {3'b0, MODE_NEXT});
    send_alloc(32'h10);
    send_reclaim(32'h0000_1000);
    send_alloc(32'h10);
    write_reg(CFG_SEG_COUNT, 5'd1);
    send_reclaim(32'h0000_0000);
    send_alloc(32'd0);
    write_reg(CFG_SEG_COUNT, 5'd4);
    send_load(4'd3, 32'hFFFF_FFFF, 32'h0000_0040);
    send_alloc(32'h8);
    send_reclaim(32'h0000_0000);
    send_alloc(32'h8);
  endtask

  // Random requests that mostly refer to what the table holds: sizes equal to
  // or next to a stored length, starts taken from the table, and loads with
  // repeated starts and lengths so that ties and duplicates keep turning up.
  function automatic seg_req_t random_req();
    seg_req_t r;
    int pick;
    int n;
    int k;
    pick = $urandom_range(99);
    n = entries_in_scan();
    k = (n > 0) ? $urandom_range(n - 1) : $urandom_range(MAX_SEGMENTS - 1);
    if (pick < 20) begin
      r = blank_req(REQ_LOAD);
      if ($urandom_range(9) < 7) r.load_start = 32'($urandom_range(15)) << 8;
      case ($urandom_range(3))
        0: r.load_length = 32'($urandom_range(32)) << 4;
        1: r.load_length = table_length[k];
        2: r.load_length = $urandom();
        default: r.load_length = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
    end else if (pick < 65) begin
      r = blank_req(REQ_ALLOC);
      case ($urandom_range(5))
        0: r.request_size = table_length[k];
        1: r.request_size = table_length[k] - 32'd1;
        2: r.request_size = table_length[k] + 32'd1;
        3: r.request_size = $urandom_range(600);
        4: r.request_size = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        default: r.request_size = $urandom();
      endcase
    end else if (pick < 95) begin
      r = blank_req(REQ_RECLAIM);
      if ($urandom_range(99) < 85) r.reclaim_start = table_start[k];
    end else begin
      r = blank_req(REQ_NONE);
    end
    return r;
  endfunction

  // Random traffic over sixteen phases. Each idling profile meets every mode
  // code, the spare one included, and the entry count moves through zero,
  // one, a middle value, the full table and the largest value the register
  // holds.
  task automatic test_random_traffic();
    logic [4:0] count_sel;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      send_load(i[3:0], 32'($urandom_range(15)) << 8, 32'($urandom_range(32)) << 4);
    end
    for (int phase = 0; phase < 16; phase++) begin
      case ((phase / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      case (phase % 5)
        0: count_sel = 5'd16;
        1: count_sel = 5'd31;
        2: count_sel = 5'($urandom_range(2, 15));
        3: count_sel = 5'd1;
        default: count_sel = 5'd0;
      endcase
      write_reg(CFG_FIT_MODE, {3'b0, fit_mode_t'(phase % 4)});
      write_reg(CFG_SEG_COUNT, count_sel);
      repeat (108) send_item(random_req());
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_FIT_MODE;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = REQ_NONE;
    m_tready = 1'b1;
    // Reset state of the table copy: all free, no next fit pointer yet.
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      table_start[i] = '0;
      table_length[i] = '0;
      table_busy[i] = 1'b0;
    end
    next_fit_index = '0;
    next_fit_valid = 1'b0;
    policy = MODE_FIRST;
    entries_cfg = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_load_entries();
    test_first_fit();
    test_reclaim();
    test_best_fit();
    test_next_fit();
    test_random_traffic();

    // Drain: everything predicted must come back, then a short tail catches
    // any stray result.
    drop_valid();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
